/* src/olvspwm_pkg.sv */
// Shared widths, stage indices, constants and payload types for the
// open-loop voltage SPWM pipeline. No dependencies.
package olvspwm_pkg;

    // field widths
    localparam int W_VOLT = 16;
    localparam int W_ANG  = 16;
    localparam int W_DUTY = 16;

    // datapath widths
    localparam int W_DIV  = 24;   // divider remainder / divisor / quotient
    localparam int W_ROOT = 24;   // square root of a 48-bit radicand
    localparam int W_REM  = 26;   // square-root partial remainder
    localparam int W_X    = 48;   // radicand
    localparam int W_D16  = 24;   // d/q and trig words
    localparam int W_AB   = 26;   // alpha / beta
    localparam int W_M    = 45;   // duty numerators

    // cell counts
    localparam int SQRT_N   = 24;
    localparam int SCL_N    = 23;
    localparam int DTY_N    = 17;
    localparam int TRIG_LAT = 4;

    // stage indices (register rank along the pipe)
    localparam int S_IN   = 0;
    localparam int S_SQ   = 1;
    localparam int S_SUM  = 2;
    localparam int S_ROOT = S_SUM + SQRT_N;
    localparam int S_PROD = S_ROOT + 1;
    localparam int S_QUO  = S_PROD + SCL_N;
    localparam int S_D16  = S_QUO + 1;
    localparam int S_MUL  = S_D16 + 1;
    localparam int S_AB   = S_MUL + 1;
    localparam int S_N    = S_AB + 1;
    localparam int S_M    = S_N + 1;
    localparam int S_MAG  = S_M + 1;
    localparam int S_PREP = S_MAG + 1;
    localparam int S_QD   = S_PREP + DTY_N;
    localparam int S_OUT  = S_QD + 1;

    // sine polynomial, Q.22
    localparam logic [22:0] TRIG_ONE = 23'h40_0000;
    localparam logic [22:0] SIN_A    = 23'd6588397;
    localparam logic [21:0] SIN_B    = 22'd2691031;
    localparam logic [18:0] SIN_C    = 19'd296941;

    // duty scaling
    localparam logic signed [W_M-1:0] K_U   = 45'sd32000;
    localparam logic signed [W_M-1:0] K_B   = 45'sd433;
    localparam logic signed [W_M-1:0] K_A   = 45'sd250;
    localparam logic signed [W_M-1:0] K_DEN = 45'sd125;
    localparam logic [W_DIV-1:0]      DEN_STEP = 24'd250;

    localparam logic [W_DUTY-1:0] DUTY_HALF = 16'h8000;
    localparam logic [W_DUTY-1:0] DUTY_MAX  = 16'hFFFF;
    localparam logic [W_DUTY-1:0] DUTY_MIN  = 16'h0000;

    typedef struct packed {
        logic [W_DIV-1:0] rem;
        logic [W_DIV-1:0] den;
        logic [W_DIV-1:0] pend;
        logic [W_DIV-1:0] quo;
    } t_div;

    typedef struct packed {
        logic [W_REM-1:0]  rem;
        logic [W_ROOT-1:0] root;
        logic [W_X-1:0]    xs;
    } t_sqrt;

    typedef struct packed {
        logic [W_VOLT-1:0] vd;
        logic [W_VOLT-1:0] vq;
        logic [W_ANG-1:0]  ang;
        logic [W_VOLT-1:0] bus;
        logic              over;
        logic [2:0]        neg;
        logic [2:0]        ovf;
    } t_side;

    function automatic logic [W_VOLT-1:0] abs_volt(input logic [W_VOLT-1:0] v);
        return v[W_VOLT-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

/* src/olvspwm_div_cell.sv */
// One restoring-division step: brings down one dividend bit, yields one
// quotient bit, registered. Depends on olvspwm_pkg.
module olvspwm_div_cell
    import olvspwm_pkg::*;
(
    input  logic i_clk,
    input  logic i_adv,
    input  t_div i_d,
    output t_div o_d
);

    logic [W_DIV:0] trial;
    logic           ge;
    t_div           n_d;
    t_div           r_d;

    always_comb begin
        trial    = {i_d.rem, i_d.pend[W_DIV-1]};
        ge       = trial >= {1'b0, i_d.den};
        n_d.den  = i_d.den;
        n_d.pend = {i_d.pend[W_DIV-2:0], 1'b0};
        n_d.quo  = {i_d.quo[W_DIV-2:0], ge};
        n_d.rem  = ge ? W_DIV'(trial - {1'b0, i_d.den}) : trial[W_DIV-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* src/olvspwm_sqrt_cell.sv */
// One digit-by-digit square-root step: two radicand bits in, one root
// bit out, registered. Depends on olvspwm_pkg.
module olvspwm_sqrt_cell
    import olvspwm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_adv,
    input  t_sqrt i_d,
    output t_sqrt o_d
);

    logic [W_REM+1:0] rem2;
    logic [W_REM-1:0] trial;
    logic             ge;
    t_sqrt            n_d;
    t_sqrt            r_d;

    always_comb begin
        rem2     = {i_d.rem, i_d.xs[W_X-1:W_X-2]};
        trial    = {i_d.root, 2'b01};
        ge       = rem2 >= {2'b00, trial};
        n_d.rem  = ge ? W_REM'(rem2 - {2'b00, trial}) : rem2[W_REM-1:0];
        n_d.root = {i_d.root[W_ROOT-2:0], ge};
        n_d.xs   = {i_d.xs[W_X-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

/* src/olvspwm_trig.sv */
// Sine and cosine of a 16-bit angle, Q.22, by a quarter-wave polynomial
// over four registered stages. Depends on olvspwm_pkg.
module olvspwm_trig
    import olvspwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_adv,
    input  logic [W_ANG-1:0]        i_angle,
    output logic signed [W_D16-1:0] o_sin,
    output logic signed [W_D16-1:0] o_cos
);

    logic signed [W_D16-1:0] w_res [2];

    for (genvar g = 0; g < 2; g++) begin : g_lane
        logic [23:0] ph;
        logic [22:0] x0;
        logic [45:0] xx;
        logic [41:0] pc;
        logic [44:0] pt;
        logic [45:0] px;
        logic [23:0] mag;
        logic [22:0] cl;
        logic [22:0] r_xa, r_xb, r_xc, r_sq, r_sqb, r_t4;
        logic [21:0] r_t2;
        logic        r_na, r_nb, r_nc;
        logic signed [W_D16-1:0] r_out;

        // cosine lane runs a quarter turn ahead
        assign ph  = {i_angle, 8'h00} + ((g == 1) ? {1'b0, TRIG_ONE} : 24'd0);
        assign x0  = ph[22] ? 23'(TRIG_ONE - {1'b0, ph[21:0]}) : {1'b0, ph[21:0]};
        assign xx  = {23'd0, x0} * {23'd0, x0};
        assign pc  = {23'd0, SIN_C} * {19'd0, r_sq};
        assign pt  = {23'd0, r_t2} * {22'd0, r_sqb};
        assign px  = {23'd0, r_t4} * {23'd0, r_xc};
        assign mag = px[45:22];
        assign cl  = (mag > {1'b0, TRIG_ONE}) ? TRIG_ONE : mag[22:0];

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_xa  <= x0;
                r_na  <= ph[23];
                r_sq  <= xx[44:22];
                r_xb  <= r_xa;
                r_nb  <= r_na;
                r_sqb <= r_sq;
                r_t2  <= SIN_B - {2'b00, pc[41:22]};
                r_xc  <= r_xb;
                r_nc  <= r_nb;
                r_t4  <= SIN_A - pt[44:22];
                r_out <= r_nc ? -$signed({1'b0, cl}) : $signed({1'b0, cl});
            end
        end

        assign w_res[g] = r_out;
    end

    assign o_sin = w_res[0];
    assign o_cos = w_res[1];

endmodule

/* src/open_loop_voltage_spwm.sv */
// Top level of the open-loop voltage SPWM block: d/q limit, inverse
// Park/Clarke and duty division. Depends on olvspwm_pkg and the cells.
//
// Takes a d/q voltage command (signed Q8.8), a 16-bit electrical angle and
// an unsigned Q8.8 bus voltage, and returns three Q0.16 phase duties. The
// vector is limited to bus/2, rotated, split into three phases and divided
// by the bus; a zero bus gives one half on every phase. The block is a
// fixed pipeline of 76 register ranks: a chain of 24 square-root cells
// finds the vector magnitude, two chains of 23 divider cells scale d and q,
// and three chains of 17 divider cells form the duties. While the pipe
// advances, each cell retires one bit per cycle and hands its word to the
// next, so one transfer is taken every cycle. A stall on the output
// freezes the whole pipe; o_stall rises only while a finished result is
// held there.
module open_loop_voltage_spwm
    import olvspwm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [W_VOLT-1:0] i_volt_d,
    input  logic signed [W_VOLT-1:0] i_volt_q,
    input  logic [W_ANG-1:0]         i_angle,
    input  logic [W_VOLT-1:0]        i_bus_volt,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [W_DUTY-1:0]        o_duty_u,
    output logic [W_DUTY-1:0]        o_duty_v,
    output logic [W_DUTY-1:0]        o_duty_w
);

    logic           adv;
    logic [S_OUT:0] r_vld;
    t_side          r_side [S_OUT+1];

    // pipe moves whenever the output rank is free or being taken
    assign adv     = !r_vld[S_OUT] || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[S_OUT-1:0], i_valid};
        end
    end

    // side data travels with the item; flags are filled in on the way
    logic       w_over;
    logic [2:0] w_neg;
    logic [2:0] w_ovf;

    for (genvar k = 0; k <= S_OUT; k++) begin : g_side
        t_side n_side;
        if (k == S_IN) begin : g_first
            always_comb begin
                n_side      = '0;
                n_side.vd   = i_volt_d;
                n_side.vq   = i_volt_q;
                n_side.ang  = i_angle;
                n_side.bus  = i_bus_volt;
            end
        end else begin : g_next
            always_comb begin
                n_side = r_side[k-1];
                if (k == S_SUM) begin
                    n_side.over = w_over;
                end
                if (k == S_MAG) begin
                    n_side.neg = w_neg;
                end
                if (k == S_PREP) begin
                    n_side.ovf = w_ovf;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_side[k] <= n_side;
            end
        end
    end

    // ---- squares and limit test --------------------------------------
    logic [31:0] r_sqd, r_sqq, r_bb;
    logic [15:0] w_ad, w_aq;
    logic [32:0] w_sum;
    t_sqrt       r_sq0;

    assign w_ad   = abs_volt(r_side[S_IN].vd);
    assign w_aq   = abs_volt(r_side[S_IN].vq);
    assign w_sum  = {1'b0, r_sqd} + {1'b0, r_sqq};
    // limit when the vector is longer than bus/2
    assign w_over = {w_sum, 2'b00} > {3'b000, r_bb};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sqd <= {16'd0, w_ad} * {16'd0, w_ad};
            r_sqq <= {16'd0, w_aq} * {16'd0, w_aq};
            r_bb  <= {16'd0, r_side[S_IN].bus} * {16'd0, r_side[S_IN].bus};
            r_sq0.rem  <= '0;
            r_sq0.root <= '0;
            r_sq0.xs   <= {w_sum[31:0], 16'd0};
        end
    end

    // ---- magnitude: square-root cell chain ---------------------------
    t_sqrt w_sq [SQRT_N+1];
    assign w_sq[0] = r_sq0;

    for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
        olvspwm_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_d   (w_sq[i]),
            .o_d   (w_sq[i+1])
        );
    end

    // ---- scale d and q by bus*2^15/magnitude -------------------------
    t_div w_sd [2][SCL_N+1];
    t_div r_sd [2];

    for (genvar l = 0; l < 2; l++) begin : g_scale
        logic [15:0] a;
        logic [31:0] prod;
        logic [45:0] num;

        assign a    = abs_volt((l == 0) ? r_side[S_ROOT].vd : r_side[S_ROOT].vq);
        assign prod = {16'd0, a} * {16'd0, r_side[S_ROOT].bus};
        assign num  = {prod[30:0], 15'd0};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sd[l].rem  <= {1'b0, num[45:23]};
                r_sd[l].den  <= w_sq[SQRT_N].root;
                r_sd[l].pend <= {num[22:0], 1'b0};
                r_sd[l].quo  <= '0;
            end
        end

        assign w_sd[l][0] = r_sd[l];

        for (genvar i = 0; i < SCL_N; i++) begin : g_cell
            olvspwm_div_cell u_cell (
                .i_clk (i_clk),
                .i_adv (adv),
                .i_d   (w_sd[l][i]),
                .o_d   (w_sd[l][i+1])
            );
        end
    end

    // ---- limited d/q in Q.16 -----------------------------------------
    logic signed [W_D16-1:0] r_d16, r_q16;
    logic [W_D16-1:0]        w_sd_d, w_sd_q;

    assign w_sd_d = {1'b0, w_sd[0][SCL_N].quo[SCL_N-1:0]};
    assign w_sd_q = {1'b0, w_sd[1][SCL_N].quo[SCL_N-1:0]};

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_side[S_QUO].over) begin
                r_d16 <= r_side[S_QUO].vd[W_VOLT-1] ? -w_sd_d : w_sd_d;
                r_q16 <= r_side[S_QUO].vq[W_VOLT-1] ? -w_sd_q : w_sd_q;
            end else begin
                r_d16 <= {r_side[S_QUO].vd, 8'h00};
                r_q16 <= {r_side[S_QUO].vq, 8'h00};
            end
        end
    end

    // ---- sine/cosine, lined up with the d/q rank ---------------------
    logic signed [W_D16-1:0] w_sin, w_cos;

    olvspwm_trig u_trig (
        .i_clk   (i_clk),
        .i_adv   (adv),
        .i_angle (r_side[S_D16-TRIG_LAT].ang),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // ---- inverse Park ------------------------------------------------
    logic signed [47:0]     r_dc, r_qs, r_ds, r_qc;
    logic signed [48:0]     w_alpha_f, w_beta_f;
    logic signed [W_AB-1:0] r_alpha, r_beta;

    assign w_alpha_f = r_dc - r_qs;
    assign w_beta_f  = r_ds + r_qc;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dc    <= r_d16 * w_cos;
            r_qs    <= r_q16 * w_sin;
            r_ds    <= r_d16 * w_sin;
            r_qc    <= r_q16 * w_cos;
            r_alpha <= w_alpha_f[47:22];
            r_beta  <= w_beta_f[47:22];
        end
    end

    // ---- inverse Clarke and duty numerators --------------------------
    logic signed [W_M-1:0] w_ae, w_be;
    logic signed [W_M-1:0] r_n [3];
    logic signed [W_M-1:0] r_m [3];
    logic [W_M-2:0]        r_mag [3];
    logic signed [W_M-1:0] w_den55, w_dd56;
    logic [W_DIV-1:0]      w_dd57;

    assign w_ae    = r_alpha;
    assign w_be    = r_beta;
    assign w_den55 = $signed({{(W_M-W_VOLT){1'b0}}, r_side[S_N].bus}) * K_DEN;
    assign w_dd56  = $signed({{(W_M-W_VOLT){1'b0}}, r_side[S_M].bus}) * K_A;
    assign w_dd57  = {8'h00, r_side[S_MAG].bus} * DEN_STEP;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n[0] <= w_ae * K_U;
            r_n[1] <= (w_be * K_B - w_ae * K_A) <<< 6;
            r_n[2] <= (-(w_be * K_B) - w_ae * K_A) <<< 6;
        end
    end

    // ---- duty division chains ----------------------------------------
    t_div w_dp [3][DTY_N+1];
    t_div r_dp [3];

    for (genvar l = 0; l < 3; l++) begin : g_duty
        logic signed [W_M-1:0] mag_s;

        // negative numerators divide with a ceiling so the result floors
        assign w_neg[l] = r_m[l][W_M-1];
        assign mag_s    = w_neg[l] ? (w_dd56 - 45'sd1 - r_m[l]) : r_m[l];
        assign w_ovf[l] = r_mag[l][W_M-2:DTY_N] >= {3'b000, w_dd57};

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_m[l]      <= (r_n[l] <<< 1) + w_den55;
                r_mag[l]    <= mag_s[W_M-2:0];
                r_dp[l].rem  <= r_mag[l][DTY_N+W_DIV-1:DTY_N];
                r_dp[l].den  <= w_dd57;
                r_dp[l].pend <= {r_mag[l][DTY_N-1:0], {(W_DIV-DTY_N){1'b0}}};
                r_dp[l].quo  <= '0;
            end
        end

        assign w_dp[l][0] = r_dp[l];

        for (genvar i = 0; i < DTY_N; i++) begin : g_cell
            olvspwm_div_cell u_cell (
                .i_clk (i_clk),
                .i_adv (adv),
                .i_d   (w_dp[l][i]),
                .o_d   (w_dp[l][i+1])
            );
        end
    end

    // ---- output rank: offset, saturate, bus-off ----------------------
    logic [W_DUTY-1:0] r_duty [3];

    for (genvar l = 0; l < 3; l++) begin : g_out
        logic [DTY_N-1:0]  q;
        logic [W_DUTY-1:0] n_duty;

        assign q = w_dp[l][DTY_N].quo[DTY_N-1:0];

        always_comb begin
            if (r_side[S_QD].bus == '0) begin
                n_duty = DUTY_HALF;
            end else if (!r_side[S_QD].neg[l]) begin
                if (r_side[S_QD].ovf[l] || q >= 17'd32767) begin
                    n_duty = DUTY_MAX;
                end else begin
                    n_duty = W_DUTY'({1'b0, DUTY_HALF} + q);
                end
            end else begin
                if (r_side[S_QD].ovf[l] || q >= 17'd32768) begin
                    n_duty = DUTY_MIN;
                end else begin
                    n_duty = W_DUTY'({1'b0, DUTY_HALF} - q);
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_duty[l] <= n_duty;
            end
        end
    end

    assign o_duty_u = r_duty[0];
    assign o_duty_v = r_duty[1];
    assign o_duty_w = r_duty[2];

    // ---- checks ------------------------------------------------------
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)
    ) else $error("input stalled without a held result");

    a_last_rank_moves: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_vld[S_OUT-1]) |=> o_valid
    ) else $error("item lost at the output rank");

    a_bus_off_half: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_side[S_OUT].bus == '0) |->
            (o_duty_u == DUTY_HALF && o_duty_v == DUTY_HALF && o_duty_w == DUTY_HALF)
    ) else $error("bus off but duties not at one half");

    a_u_sign: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_side[S_OUT].bus != '0 && !r_side[S_OUT].neg[0]) |->
            (o_duty_u >= DUTY_HALF)
    ) else $error("positive U numerator gave a duty below one half");

endmodule
